// ----- rtl/core/rsi_pkg.sv -----
// Shared widths, codes and bundle types for the ray-sphere intersection core.
// No dependencies; every other file in rtl/core imports this package.
package rsi_pkg;

  localparam int CW     = 32;            // coordinate width, Q16.16
  localparam int FRAC   = 16;
  localparam int VW     = CW + 1;        // origin minus center
  localparam int AW     = 2 * CW;        // a = d.d, unsigned
  localparam int BW     = 2 * CW + 3;    // b and cc, signed
  localparam int MW     = BW - 1;        // |b|, |cc|
  localparam int HW     = MW / 2;        // half of |b|, |cc|
  localparam int AHW    = AW / 2;        // half of a
  localparam int PPW    = AHW + HW;      // a*cc partial product
  localparam int PW     = 2 * MW;        // b squared
  localparam int ACW    = AW + MW;       // a*|cc|
  localparam int DW     = PW + 3;        // discriminant, signed
  localparam int DQS    = 2 * FRAC;      // shift from 2^-64 to Q32.32
  localparam int OW     = 64;            // reported discriminant
  localparam int SW     = MW + 1;        // square root bits
  localparam int XW     = 2 * SW;        // radicand bits
  localparam int RW     = SW + 3;        // sqrt remainder
  localparam int NW     = SW + 2;        // signed numerator
  localparam int NMW    = NW - 1;        // numerator magnitude
  localparam int DENW   = AW + 1;        // 2a
  localparam int QW     = CW + 1;        // quotient bits kept
  localparam int HIW    = NMW - QW + FRAC;
  localparam int IN_TW  = 6 * CW;
  localparam int OUT_TW = 2 * CW + OW;
  localparam int CFG_IW = 3;

  localparam logic [CW-1:0] T_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] T_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef enum logic [CFG_IW-1:0] {
    REG_CENTER_X  = 3'd0,
    REG_CENTER_Y  = 3'd1,
    REG_CENTER_Z  = 3'd2,
    REG_RADIUS    = 3'd3,
    REG_MISS_DIST = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [AW-1:0]        a;
    logic signed [BW-1:0] b;
    logic signed [BW-1:0] cc;
  } quad_t;

  typedef struct packed {
    logic [AW-1:0]        a;
    logic signed [BW-1:0] b;
    logic [OW-1:0]        disc_q;
    logic                 hit;
  } sq_side_t;

  typedef struct packed {
    logic [OW-1:0] disc_q;
    logic          hit;
  } div_side_t;

  // one root's division state
  typedef struct packed {
    logic [DENW-1:0] rem;
    logic [QW-1:0]   low;
    logic [QW-1:0]   q;
    logic            ovf;
    logic            neg;
  } lane_t;

endpackage

// ----- rtl/core/ray_sphere_intersect_core.sv -----
// Ray-sphere intersection core: top level, config registers, result formatting.
// Uses rsi_pkg, rsi_dot, rsi_disc, rsi_sqrt and rsi_div.
//
//  channel | dir | item
//  --------+-----+---------------------------------------------------------------
//  in_     | in  | one ray: origin xyz, direction xyz (Q16.16)
//  out_    | out | t_plus, t_minus (Q16.16), discriminant (Q32.32); tuser = hit
//  cfg_    | in  | write-only: center xyz, radius, miss distance
//
// Stages in order: dot-product, discriminant, square-root (one root bit each),
// divider (numerator, overflow, then one quotient bit each) and output.
// One item per cycle sustained. Every stage moves on a single enable that is
// low only while the output register holds an item not yet taken; a stall
// freezes the whole pipe. Reset (rst_n, synchronous) clears valid bits and
// sets the config registers to their defaults.
module ray_sphere_intersect_core
  import rsi_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  input  logic [IN_TW-1:0]  in_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  // t_plus, t_minus, discriminant
  output logic [OUT_TW-1:0] out_tdata,
  // hit
  output logic              out_tuser,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CW-1:0]     cfg_wdata
);

  logic                 en;
  logic signed [CW-1:0] center_r [3];
  logic [CW-2:0]        radius_r;
  logic [CW-2:0]        miss_dist_r;

  logic signed [CW-1:0] org [3];
  logic signed [CW-1:0] dir [3];

  logic                 dot_v;
  quad_t                quad;
  logic                 disc_v;
  logic signed [DW-1:0] disc;
  logic [AW-1:0]        disc_a;
  logic signed [BW-1:0] disc_b;

  logic [XW-1:0]        sq_x;
  logic                 disc_fits;
  sq_side_t             sq_side_in;
  logic                 sq_v;
  logic [SW-1:0]        sq_root;
  sq_side_t             sq_side;
  div_side_t            dv_side_in;

  logic                 dv_v;
  lane_t                lane [2];
  div_side_t            dv_side;

  logic [CW-1:0]        t_nxt [2];
  logic                 out_valid_r;
  logic [OUT_TW-1:0]    out_tdata_r;
  logic                 out_tuser_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r[0] <= '0;
      center_r[1] <= '0;
      center_r[2] <= '0;
      radius_r    <= (CW-1)'(65536);
      miss_dist_r <= {(CW-1){1'b1}};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER_X:  center_r[0] <= cfg_wdata;
        REG_CENTER_Y:  center_r[1] <= cfg_wdata;
        REG_CENTER_Z:  center_r[2] <= cfg_wdata;
        REG_RADIUS:    radius_r    <= cfg_wdata[CW-2:0];
        REG_MISS_DIST: miss_dist_r <= cfg_wdata[CW-2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      org[i] = in_tdata[i*CW +: CW];
      dir[i] = in_tdata[(3+i)*CW +: CW];
    end
  end

  rsi_dot u_dot (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .valid_i  (in_tvalid),
    .org_i    (org),
    .dir_i    (dir),
    .ctr_i    (center_r),
    .radius_i (radius_r),
    .valid_o  (dot_v),
    .quad_o   (quad)
  );

  rsi_disc u_disc (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (dot_v),
    .quad_i  (quad),
    .valid_o (disc_v),
    .disc_o  (disc),
    .a_o     (disc_a),
    .b_o     (disc_b)
  );

  // miss when disc < 0 or the direction is zero; disc is reported either way
  always_comb begin
    sq_x              = disc[DW-1] ? '0 : disc[XW-1:0];
    disc_fits         = (&disc[DW-1:OW+DQS-1]) || (disc[DW-1:OW+DQS-1] == '0);
    sq_side_in.a      = disc_a;
    sq_side_in.b      = disc_b;
    sq_side_in.hit    = !disc[DW-1] && (disc_a != '0);
    if (disc_fits) begin
      sq_side_in.disc_q = disc[OW+DQS-1:DQS];
    end else if (disc[DW-1]) begin
      sq_side_in.disc_q = {1'b1, {(OW-1){1'b0}}};
    end else begin
      sq_side_in.disc_q = {1'b0, {(OW-1){1'b1}}};
    end
  end

  rsi_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (disc_v),
    .x_i     (sq_x),
    .side_i  (sq_side_in),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  assign dv_side_in.disc_q = sq_side.disc_q;
  assign dv_side_in.hit    = sq_side.hit;

  rsi_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (sq_v),
    .root_i  (sq_root),
    .a_i     (sq_side.a),
    .b_i     (sq_side.b),
    .side_i  (dv_side_in),
    .valid_o (dv_v),
    .lane_o  (lane),
    .side_o  (dv_side)
  );

  // on a miss output the miss distance; else saturate the magnitude quotient into signed Q16.16
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (!dv_side.hit) begin
        t_nxt[l] = {1'b0, miss_dist_r};
      end else if (!lane[l].neg) begin
        t_nxt[l] = (lane[l].ovf || lane[l].q[QW-1:CW-1] != '0) ?
                   T_MAX : lane[l].q[CW-1:0];
      end else begin
        t_nxt[l] = (lane[l].ovf || lane[l].q[QW-1] ||
                    (lane[l].q[CW-1] && lane[l].q[CW-2:0] != '0)) ?
                   T_MIN : -lane[l].q[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= {dv_side.disc_q, t_nxt[1], t_nxt[0]};
      out_tuser_r <= dv_side.hit;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// ----- rtl/core/rsi_dot.sv -----
// Dot-product front end: forms a, b and cc of the ray-sphere quadratic.
// Three register stages. Depends on rsi_pkg.
module rsi_dot
  import rsi_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 valid_i,
  input  logic signed [CW-1:0] org_i [3],
  input  logic signed [CW-1:0] dir_i [3],
  input  logic signed [CW-1:0] ctr_i [3],
  input  logic [CW-2:0]        radius_i,
  output logic                 valid_o,
  output quad_t                quad_o
);

  logic                     v1_r, v2_r, v3_r;
  logic signed [VW-1:0]     diff_r [3];
  logic signed [CW-1:0]     dir_r  [3];
  logic signed [2*CW-1:0]   dd_r   [3];
  logic signed [VW+CW-1:0]  vd_r   [3];
  logic signed [2*VW-1:0]   vv_r   [3];
  logic [2*CW-3:0]          rr_r;
  logic signed [BW-1:0]     vd_x   [3];
  logic signed [BW-1:0]     vv_x   [3];
  logic signed [BW-1:0]     rr_x;
  logic signed [BW-1:0]     bsum;
  logic [AW-1:0]            a_nxt;
  logic signed [BW-1:0]     b_nxt;
  logic signed [BW-1:0]     cc_nxt;
  quad_t                    quad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= valid_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        diff_r[i] <= {org_i[i][CW-1], org_i[i]} - {ctr_i[i][CW-1], ctr_i[i]};
        dir_r[i]  <= dir_i[i];
        dd_r[i]   <= dir_r[i] * dir_r[i];
        vd_r[i]   <= diff_r[i] * dir_r[i];
        vv_r[i]   <= diff_r[i] * diff_r[i];
      end
      rr_r     <= radius_i * radius_i;
      quad_r.a  <= a_nxt;
      quad_r.b  <= b_nxt;
      quad_r.cc <= cc_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vd_x[i] = {{(BW-VW-CW){vd_r[i][VW+CW-1]}}, vd_r[i]};
      vv_x[i] = {{(BW-2*VW){vv_r[i][2*VW-1]}}, vv_r[i]};
    end
    rr_x   = {{(BW-2*CW+2){1'b0}}, rr_r};
    a_nxt  = dd_r[0][AW-1:0] + dd_r[1][AW-1:0] + dd_r[2][AW-1:0];
    bsum   = vd_x[0] + vd_x[1] + vd_x[2];
    b_nxt  = {bsum[BW-2:0], 1'b0};
    cc_nxt = vv_x[0] + vv_x[1] + vv_x[2] - rr_x;
  end

  assign valid_o = v3_r;
  assign quad_o  = quad_r;

endmodule

// ----- rtl/core/rsi_disc.sv -----
// Discriminant b*b - 4*a*cc, built from ~33-bit partial products.
// Three register stages. Depends on rsi_pkg.
module rsi_disc
  import rsi_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 valid_i,
  input  quad_t                quad_i,
  output logic                 valid_o,
  output logic signed [DW-1:0] disc_o,
  output logic [AW-1:0]        a_o,
  output logic signed [BW-1:0] b_o
);

  logic                 v1_r, v2_r, v3_r;
  logic signed [BW-1:0] bneg, cneg;
  logic [MW-1:0]        bm, cm;
  logic [2*HW-1:0]      bhh_r, bhl_r, bll_r;
  logic [PPW-1:0]       phh_r, phl_r, plh_r, pll_r;
  logic                 cs1_r, cs2_r;
  logic [AW-1:0]        a1_r, a2_r, a3_r;
  logic signed [BW-1:0] b1_r, b2_r, b3_r;
  logic [PW-1:0]        bsq_r, bsq_nxt;
  logic [ACW-1:0]       ac_r, ac_nxt;
  logic [DW-1:0]        bsq_x, ac4_x;
  logic signed [DW-1:0] disc_r, disc_nxt;

  always_comb begin
    bneg = -quad_i.b;
    cneg = -quad_i.cc;
    bm   = quad_i.b[BW-1] ? bneg[MW-1:0] : quad_i.b[MW-1:0];
    cm   = quad_i.cc[BW-1] ? cneg[MW-1:0] : quad_i.cc[MW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= valid_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_comb begin
    bsq_nxt = {bhh_r, {(2*HW){1'b0}}}
            + {{(PW-3*HW-1){1'b0}}, bhl_r, {(HW+1){1'b0}}}
            + {{(PW-2*HW){1'b0}}, bll_r};
    ac_nxt  = {phh_r, {PPW{1'b0}}}
            + {{(ACW-PPW-AHW){1'b0}}, phl_r, {AHW{1'b0}}}
            + {{(ACW-PPW-HW){1'b0}}, plh_r, {HW{1'b0}}}
            + {{(ACW-PPW){1'b0}}, pll_r};
    bsq_x    = {{(DW-PW){1'b0}}, bsq_r};
    ac4_x    = {{(DW-ACW-2){1'b0}}, ac_r, 2'b00};
    // sign of cc decides whether 4*a*|cc| is added or taken away
    disc_nxt = cs2_r ? bsq_x + ac4_x : bsq_x - ac4_x;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bhh_r  <= bm[MW-1:HW] * bm[MW-1:HW];
      bhl_r  <= bm[MW-1:HW] * bm[HW-1:0];
      bll_r  <= bm[HW-1:0] * bm[HW-1:0];
      phh_r  <= quad_i.a[AW-1:AHW] * cm[MW-1:HW];
      phl_r  <= quad_i.a[AW-1:AHW] * cm[HW-1:0];
      plh_r  <= quad_i.a[AHW-1:0] * cm[MW-1:HW];
      pll_r  <= quad_i.a[AHW-1:0] * cm[HW-1:0];
      cs1_r  <= quad_i.cc[BW-1];
      a1_r   <= quad_i.a;
      b1_r   <= quad_i.b;
      bsq_r  <= bsq_nxt;
      ac_r   <= ac_nxt;
      cs2_r  <= cs1_r;
      a2_r   <= a1_r;
      b2_r   <= b1_r;
      disc_r <= disc_nxt;
      a3_r   <= a2_r;
      b3_r   <= b2_r;
    end
  end

  assign valid_o = v3_r;
  assign disc_o  = disc_r;
  assign a_o     = a3_r;
  assign b_o     = b3_r;

endmodule

// ----- rtl/core/rsi_sqrt.sv -----
// Pipelined integer square root, one result bit per stage (SW stages).
// Carries the item's side data alongside. Depends on rsi_pkg.
module rsi_sqrt
  import rsi_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          valid_i,
  input  logic [XW-1:0] x_i,
  input  sq_side_t      side_i,
  output logic          valid_o,
  output logic [SW-1:0] root_o,
  output sq_side_t      side_o
);

  logic          v_r    [SW];
  logic [SW-1:0] root_r [SW];
  logic [RW-1:0] rem_r  [SW-1];
  logic [XW-1:0] x_r    [SW-1];
  sq_side_t      side_r [SW];

  for (genvar k = 0; k < SW; k++) begin : g_step
    logic          v_in;
    logic [SW-1:0] root_in;
    logic [RW-1:0] rem_in;
    logic [XW-1:0] x_in;
    sq_side_t      side_in;
    logic [RW-1:0] sh, trial;
    logic          ge;
    logic [SW-1:0] root_nxt;

    if (k == 0) begin : g_head
      assign v_in    = valid_i;
      assign root_in = '0;
      assign rem_in  = '0;
      assign x_in    = x_i;
      assign side_in = side_i;
    end else begin : g_body
      assign v_in    = v_r[k-1];
      assign root_in = root_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign x_in    = x_r[k-1];
      assign side_in = side_r[k-1];
    end

    // bring down the next two radicand bits, try (root<<2)|1
    assign sh       = {rem_in[RW-3:0], x_in[XW-1-2*k -: 2]};
    assign trial    = {{(RW-SW-2){1'b0}}, root_in, 2'b01};
    assign ge       = sh >= trial;
    assign root_nxt = {root_in[SW-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k] <= root_nxt;
        side_r[k] <= side_in;
      end
    end

    if (k < SW - 1) begin : g_carry
      logic [RW-1:0] diff;
      logic [RW-1:0] rem_nxt;
      assign diff    = sh - trial;
      assign rem_nxt = ge ? diff : sh;
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= rem_nxt;
          x_r[k]   <= x_in;
        end
      end
    end
  end

  assign valid_o = v_r[SW-1];
  assign root_o  = root_r[SW-1];
  assign side_o  = side_r[SW-1];

endmodule

// ----- rtl/core/rsi_div.sv -----
// Two-lane pipelined divider: (-b +/- s) * 2^16 / (2a), truncated toward zero.
// Numerator stage, overflow stage, then one quotient bit per stage. Depends on rsi_pkg.
module rsi_div
  import rsi_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 valid_i,
  input  logic [SW-1:0]        root_i,
  input  logic [AW-1:0]        a_i,
  input  logic signed [BW-1:0] b_i,
  input  div_side_t            side_i,
  output logic                 valid_o,
  output lane_t                lane_o [2],
  output div_side_t            side_o
);

  logic signed [NW-1:0] bx, sx;
  logic signed [NW-1:0] num  [2];
  logic signed [NW-1:0] nneg [2];
  logic [NMW-1:0]       mag_nxt [2];

  logic                 nv_r;
  logic [NMW-1:0]       mag_r [2];
  logic                 neg_r [2];
  logic [DENW-1:0]      nden_r;
  div_side_t            nside_r;

  logic [DENW-1:0]      hix [2];
  lane_t                ol  [2];

  logic                 v_r    [QW+1];
  lane_t                lane_r [QW+1][2];
  logic [DENW-1:0]      den_r  [QW];
  div_side_t            side_r [QW+1];

  always_comb begin
    bx     = {{(NW-BW){b_i[BW-1]}}, b_i};
    sx     = {{(NW-SW){1'b0}}, root_i};
    num[0] = sx - bx;
    num[1] = -bx - sx;
    for (int l = 0; l < 2; l++) begin
      nneg[l]    = -num[l];
      mag_nxt[l] = num[l][NW-1] ? nneg[l][NMW-1:0] : num[l][NMW-1:0];
    end
  end

  // quotient >= 2^QW is flagged up front; only the low QW bits are resolved
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      hix[l]    = {{(DENW-HIW){1'b0}}, mag_r[l][NMW-1:QW-FRAC]};
      ol[l].ovf = hix[l] >= nden_r;
      ol[l].rem = hix[l];
      ol[l].low = {mag_r[l][QW-FRAC-1:0], {FRAC{1'b0}}};
      ol[l].q   = '0;
      ol[l].neg = neg_r[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r   <= 1'b0;
      v_r[0] <= 1'b0;
    end else if (en) begin
      nv_r   <= valid_i;
      v_r[0] <= nv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        mag_r[l]     <= mag_nxt[l];
        neg_r[l]     <= num[l][NW-1];
        lane_r[0][l] <= ol[l];
      end
      nden_r    <= {a_i, 1'b0};
      nside_r   <= side_i;
      den_r[0]  <= nden_r;
      side_r[0] <= nside_r;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_step
    lane_t           lnxt [2];
    logic [DENW:0]   r2   [2];
    logic [DENW:0]   diff [2];
    logic            ge   [2];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        r2[l]        = {lane_r[j][l].rem, lane_r[j][l].low[QW-1-j]};
        ge[l]        = r2[l] >= {1'b0, den_r[j]};
        diff[l]      = r2[l] - {1'b0, den_r[j]};
        lnxt[l]      = lane_r[j][l];
        lnxt[l].rem  = ge[l] ? diff[l][DENW-1:0] : r2[l][DENW-1:0];
        lnxt[l].q    = {lane_r[j][l].q[QW-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j+1] <= 1'b0;
      end else if (en) begin
        v_r[j+1] <= v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        lane_r[j+1][0] <= lnxt[0];
        lane_r[j+1][1] <= lnxt[1];
        side_r[j+1]    <= side_r[j];
      end
    end

    if (j < QW - 1) begin : g_den
      always_ff @(posedge clk) begin
        if (en) begin
          den_r[j+1] <= den_r[j];
        end
      end
    end
  end

  assign valid_o   = v_r[QW];
  assign lane_o[0] = lane_r[QW][0];
  assign lane_o[1] = lane_r[QW][1];
  assign side_o    = side_r[QW];

endmodule
